// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/rafs_pkg.sv =====
// Shared constants, command codes and control types of the register/flags/stack unit.
package rafs_pkg;

    localparam int unsigned RAFS_NUM_REGS    = 32;
    localparam int unsigned RAFS_STACK_DEPTH = 64;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CMD_W  = 5;
    localparam int unsigned IDX_W  = 5;

    // Instruction codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 5'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 5'd1;
    localparam logic [CMD_W-1:0] CMD_AND  = 5'd2;
    localparam logic [CMD_W-1:0] CMD_XOR  = 5'd3;
    localparam logic [CMD_W-1:0] CMD_OR   = 5'd4;
    localparam logic [CMD_W-1:0] CMD_ADDI = 5'd5;
    localparam logic [CMD_W-1:0] CMD_ORI  = 5'd9;
    localparam logic [CMD_W-1:0] CMD_MOVI = 5'd10;
    localparam logic [CMD_W-1:0] CMD_MOVR = 5'd11;
    localparam logic [CMD_W-1:0] CMD_SWP  = 5'd12;
    localparam logic [CMD_W-1:0] CMD_MULL = 5'd13;
    localparam logic [CMD_W-1:0] CMD_DIV  = 5'd14;
    localparam logic [CMD_W-1:0] CMD_PUSH = 5'd15;
    localparam logic [CMD_W-1:0] CMD_POP  = 5'd16;
    localparam logic [CMD_W-1:0] CMD_SKIE = 5'd17;
    localparam logic [CMD_W-1:0] CMD_READ = 5'd18;

    // Multiply result nibble masks
    localparam logic [DATA_W-1:0] MUL_HI_MASK = 32'd240;
    localparam logic [DATA_W-1:0] MUL_LO_MASK = 32'd15;
    localparam int unsigned DIV_STEPS = 32;

    typedef struct packed {
        logic load;
        logic rd;
        logic ex;
        logic mul_wr;
        logic div_step;
        logic div_wr;
        logic wr2;
        logic pop_wr;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_swp;
        logic is_mul;
        logic is_div;
        logic div_zero;
        logic pop_go;
        logic out_free;
    } ctrl_sts_t;

    // Parity, zero and sign of a result
    function automatic logic [2:0] psz_f(input logic [DATA_W-1:0] r);
        return {^r, (r == '0), r[DATA_W-1]};
    endfunction

endpackage

// ===== sv/rafs_req_if.sv =====
// Instruction item channel.
interface rafs_req_if
    import rafs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         dest_reg;
    logic [IDX_W-1:0]         src_a;
    logic [IDX_W-1:0]         src_b;
    logic signed [DATA_W-1:0] immediate;

    modport source (output valid, cmd, dest_reg, src_a, src_b, immediate, input ready);
    modport sink (input valid, cmd, dest_reg, src_a, src_b, immediate, output ready);
endinterface

// ===== sv/rafs_rsp_if.sv =====
// Result item channel.
interface rafs_rsp_if
    import rafs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     parity_flag;
    logic                     zero_flag;
    logic                     sign_flag;
    logic                     overflow_flag;
    logic                     skip_next;
    logic                     div_error;

    modport source (output valid, value, parity_flag, zero_flag, sign_flag, overflow_flag,
                    skip_next, div_error, input ready);
    modport sink (input valid, value, parity_flag, zero_flag, sign_flag, overflow_flag,
                  skip_next, div_error, output ready);
endinterface

// ===== sv/rafs_ctrl.sv =====
// Sequencing state machine of the register/flags/stack unit.
module rafs_ctrl
    import rafs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DVW  = 3'd5;
    localparam logic [2:0] S_W2   = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;
    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop_reg, pop_next;

    assign in_ready = (state_reg == S_IDLE);

    // Decode state into datapath commands and pick the next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pop_next   = pop_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EX;
            end
            S_EX:
            begin
                cmd.ex     = 1'b1;
                cnt_next   = '0;
                pop_next   = sts.pop_go;
                state_next = S_DONE;
                if (sts.is_swp)
                    state_next = S_W2;
                else if (sts.is_mul)
                    state_next = S_MUL;
                else if (sts.is_div && !sts.div_zero)
                    state_next = S_DIV;
            end
            S_MUL:
            begin
                cmd.mul_wr = 1'b1;
                state_next = S_W2;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_DVW;
            end
            S_DVW:
            begin
                cmd.div_wr = 1'b1;
                state_next = S_W2;
            end
            S_W2:
            begin
                cmd.wr2    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Stack data arrives in the cycle after EX; write it before handing out
                if (pop_reg)
                begin
                    cmd.pop_wr = 1'b1;
                    pop_next   = 1'b0;
                end
                else if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pop_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pop_reg   <= pop_next;
        end
    end
endmodule

// ===== sv/rafs_dp.sv =====
// Datapath: register file, flags, stack, multiplier, divider and result register.
module rafs_dp
    import rafs_pkg::*;
#(
    parameter int unsigned NUM_REGS    = RAFS_NUM_REGS,
    parameter int unsigned STACK_DEPTH = RAFS_STACK_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    output ctrl_sts_t sts,
    rafs_req_if.sink  req,
    rafs_rsp_if.source rsp
);
    localparam int unsigned RW = $clog2(NUM_REGS);
    localparam int unsigned SW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    // Register index wrap table
    logic [RW-1:0] ridx_tab [2**IDX_W];
    for (genvar gi = 0; gi < 2**IDX_W; gi++)
    begin : g_ridx
        localparam int unsigned M = gi % NUM_REGS;
        assign ridx_tab[gi] = RW'(M);
    end

    logic [CMD_W-1:0]  cmd_reg;
    logic [RW-1:0]     d_reg, a_reg, b_reg;
    logic [DATA_W-1:0] imm_reg;

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= req.cmd;
            d_reg   <= ridx_tab[req.dest_reg];
            a_reg   <= ridx_tab[req.src_a];
            b_reg   <= ridx_tab[req.src_b];
            imm_reg <= DATA_W'(req.immediate);
        end
    end

    // Register file memory with entry valid bits
    logic [DATA_W-1:0] rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_vld_reg;
    logic [DATA_W-1:0] xq_reg, yq_reg;
    logic              xv_reg, yv_reg;
    logic              wr_en;
    logic [RW-1:0]     wr_addr, ra;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] x, y;

    assign ra = (cmd_reg == CMD_READ) ? '0 : a_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            rf_mem[wr_addr] <= wr_data;
        if (cmd.rd)
        begin
            xq_reg <= rf_mem[ra];
            yq_reg <= rf_mem[b_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg <= '0;
            xv_reg     <= 1'b0;
            yv_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
                rf_vld_reg[wr_addr] <= 1'b1;
            if (cmd.rd)
            begin
                xv_reg <= rf_vld_reg[ra];
                yv_reg <= rf_vld_reg[b_reg];
            end
        end
    end

    assign x = xv_reg ? xq_reg : '0;
    assign y = yv_reg ? yq_reg : '0;

    // ALU
    logic              is_alu, is_imm;
    logic [CMD_W-1:0]  alu_op;
    logic [DATA_W-1:0] opnd, alu_r;
    logic              alu_ovf;

    assign is_alu = (cmd_reg <= CMD_ORI);
    assign is_imm = (cmd_reg >= CMD_ADDI);
    assign opnd   = is_imm ? imm_reg : y;
    assign alu_op = is_imm ? (cmd_reg - CMD_ADDI) : cmd_reg;

    always_comb
    begin
        alu_ovf = 1'b0;
        case (alu_op)
            CMD_ADD:
            begin
                alu_r   = x + opnd;
                alu_ovf = ~(x[DATA_W-1] ^ opnd[DATA_W-1]) & (x[DATA_W-1] ^ alu_r[DATA_W-1]);
            end
            CMD_SUB:
            begin
                alu_r   = x - opnd;
                alu_ovf = (x[DATA_W-1] ^ opnd[DATA_W-1]) & (x[DATA_W-1] ^ alu_r[DATA_W-1]);
            end
            CMD_AND: alu_r = x & opnd;
            CMD_XOR: alu_r = x ^ opnd;
            default: alu_r = x | opnd;
        endcase
    end

    // Multiplier, registered product
    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       mul_ovf;

    always_ff @(posedge clk)
    begin
        if (cmd.ex)
            prod_reg <= $signed(x) * $signed(y);
    end

    assign mul_ovf = !((&prod_reg[2*DATA_W-1:DATA_W-1]) || !(|prod_reg[2*DATA_W-1:DATA_W-1]));

    // Restoring divider on magnitudes, one quotient bit per step
    logic [DATA_W-1:0] dv_rem_reg, dv_quo_reg, dv_m_reg;
    logic              dv_sq_reg, dv_sr_reg;
    logic [DATA_W:0]   dv_t, dv_diff;
    logic              dv_ge;
    logic [DATA_W-1:0] quo_fix, rem_fix, div_flag_src;

    assign dv_t    = {dv_rem_reg, dv_quo_reg[DATA_W-1]};
    assign dv_diff = dv_t - {1'b0, dv_m_reg};
    assign dv_ge   = (dv_t >= {1'b0, dv_m_reg});
    assign quo_fix = dv_sq_reg ? (~dv_quo_reg + 1'b1) : dv_quo_reg;
    assign rem_fix = dv_sr_reg ? (~dv_rem_reg + 1'b1) : dv_rem_reg;
    // Flags follow the final content of the quotient register; with the same
    // register for both, the remainder lands there last
    assign div_flag_src = (a_reg == b_reg) ? rem_fix : quo_fix;

    always_ff @(posedge clk)
    begin
        if (cmd.ex)
        begin
            dv_quo_reg <= x[DATA_W-1] ? (~x + 1'b1) : x;
            dv_m_reg   <= y[DATA_W-1] ? (~y + 1'b1) : y;
            dv_rem_reg <= '0;
            dv_sq_reg  <= x[DATA_W-1] ^ y[DATA_W-1];
            dv_sr_reg  <= x[DATA_W-1];
        end
        else if (cmd.div_step)
        begin
            dv_rem_reg <= dv_ge ? dv_diff[DATA_W-1:0] : dv_t[DATA_W-1:0];
            dv_quo_reg <= {dv_quo_reg[DATA_W-2:0], dv_ge};
        end
    end

    // Stack memory as a ring; a push on a full stack overwrites the oldest entry
    logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
    logic [SW-1:0]     sp_reg, sp_inc, sp_dec;
    logic [CW-1:0]     cnt_reg;
    logic [DATA_W-1:0] stk_q_reg;
    logic              do_push, do_pop;

    assign sp_inc  = (sp_reg == SW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec  = (sp_reg == '0) ? SW'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign do_push = cmd.ex && (cmd_reg == CMD_PUSH);
    assign do_pop  = cmd.ex && (cmd_reg == CMD_POP) && (cnt_reg != '0);

    always_ff @(posedge clk)
    begin
        if (do_push)
            stk_mem[sp_reg] <= x;
        if (do_pop)
            stk_q_reg <= stk_mem[sp_dec];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (do_push)
        begin
            sp_reg <= sp_inc;
            if (cnt_reg != CW'(STACK_DEPTH))
                cnt_reg <= cnt_reg + 1'b1;
        end
        else if (do_pop)
        begin
            sp_reg  <= sp_dec;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Select the register file write
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = d_reg;
        wr_data = alu_r;
        if (cmd.ex)
        begin
            if (is_alu)
                wr_en = 1'b1;
            else if (cmd_reg == CMD_MOVI)
            begin
                wr_en   = 1'b1;
                wr_data = imm_reg;
            end
            else if (cmd_reg == CMD_MOVR)
            begin
                wr_en   = 1'b1;
                wr_data = x;
            end
            else if (cmd_reg == CMD_SWP)
            begin
                wr_en   = 1'b1;
                wr_addr = a_reg;
                wr_data = y;
            end
            else if (cmd_reg == CMD_POP && cnt_reg == '0)
            begin
                wr_en   = 1'b1;
                wr_addr = a_reg;
                wr_data = '0;
            end
        end
        else if (cmd.mul_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = a_reg;
            wr_data = (prod_reg[DATA_W-1:0] & MUL_HI_MASK) >> 4;
        end
        else if (cmd.div_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = a_reg;
            wr_data = quo_fix;
        end
        else if (cmd.pop_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = a_reg;
            wr_data = stk_q_reg;
        end
        else if (cmd.wr2)
        begin
            wr_en   = 1'b1;
            wr_addr = b_reg;
            if (cmd_reg == CMD_SWP)
                wr_data = x;
            else if (cmd_reg == CMD_MULL)
                wr_data = prod_reg[DATA_W-1:0] & MUL_LO_MASK;
            else
                wr_data = rem_fix;
        end
    end

    // Flags
    logic par_reg, zero_reg, sign_reg, ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_reg  <= 1'b0;
            zero_reg <= 1'b0;
            sign_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.ex && is_alu)
        begin
            {par_reg, zero_reg, sign_reg} <= psz_f(alu_r);
            if (alu_op == CMD_ADD || alu_op == CMD_SUB)
                ovf_reg <= alu_ovf;
        end
        else if (cmd.mul_wr)
        begin
            {par_reg, zero_reg, sign_reg} <= psz_f(prod_reg[DATA_W-1:0]);
            ovf_reg <= mul_ovf;
        end
        else if (cmd.div_wr)
        begin
            {par_reg, zero_reg, sign_reg} <= psz_f(div_flag_src);
        end
    end

    // Collect the result of the item
    logic [DATA_W-1:0] val_reg;
    logic              skip_reg, derr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ex)
        begin
            skip_reg <= (cmd_reg == CMD_SKIE) && (x == y);
            derr_reg <= (cmd_reg == CMD_DIV) && (y == '0);
            if (is_alu)
                val_reg <= alu_r;
            else if (cmd_reg == CMD_MOVI)
                val_reg <= imm_reg;
            else if (cmd_reg == CMD_MOVR || cmd_reg == CMD_SWP || cmd_reg == CMD_PUSH ||
                     cmd_reg == CMD_READ)
                val_reg <= x;
            else
                val_reg <= '0;
        end
        else if (cmd.mul_wr)
            val_reg <= prod_reg[DATA_W-1:0] & MUL_LO_MASK;
        else if (cmd.div_wr)
            val_reg <= rem_fix;
        else if (cmd.pop_wr)
            val_reg <= stk_q_reg;
    end

    // Output register
    logic out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.out_load)
            out_vld_reg <= 1'b1;
        else if (rsp.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp.value         <= $signed(val_reg);
            rsp.parity_flag   <= par_reg;
            rsp.zero_flag     <= zero_reg;
            rsp.sign_flag     <= sign_reg;
            rsp.overflow_flag <= ovf_reg;
            rsp.skip_next     <= skip_reg;
            rsp.div_error     <= derr_reg;
        end
    end

    assign rsp.valid = out_vld_reg;

    // Status to the controller
    assign sts.is_swp   = (cmd_reg == CMD_SWP);
    assign sts.is_mul   = (cmd_reg == CMD_MULL);
    assign sts.is_div   = (cmd_reg == CMD_DIV);
    assign sts.div_zero = (y == '0);
    assign sts.pop_go   = (cmd_reg == CMD_POP) && (cnt_reg != '0);
    assign sts.out_free = !out_vld_reg || rsp.ready;
endmodule

// ===== sv/register_alu_flags_stack_unit.sv =====
// Top level of the register/flags/stack unit.
// Executes one decoded instruction per item on a file of NUM_REGS 32-bit registers with
// parity, zero, sign and overflow flags and a STACK_DEPTH-entry stack. One item is in work at
// a time: the next item is accepted only after the last has loaded its result into the
// output register. Swap, multiply and divide make two writes through the single register
// file write port; divide first runs the 32-step iterative divider, and on a zero divisor
// it skips the divider and both writes. A finished result waits in the output register
// while the next item is accepted.
`include "assert_macros.svh"
module register_alu_flags_stack_unit
    import rafs_pkg::*;
#(
    parameter int unsigned NUM_REGS    = RAFS_NUM_REGS,
    parameter int unsigned STACK_DEPTH = RAFS_STACK_DEPTH
)
(
    input logic        clk,
    input logic        rst_n,
    rafs_req_if.sink   req,
    rafs_rsp_if.source rsp
);
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    rafs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rafs_dp #(
        .NUM_REGS    (NUM_REGS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

    // One item in work at a time
    `ASSERT_NEXT(a_one_item, clk, rst_n, req.valid && req.ready, !req.ready)
    // Never overwrite a result that is still waiting
    `ASSERT_IMPLIES(a_out_free, clk, rst_n, cmd.out_load, !rsp.valid || rsp.ready)
    // A divide error carries a zero value
    `ASSERT_IMPLIES(a_derr_zero, clk, rst_n, rsp.valid && rsp.div_error, rsp.value == 0)
endmodule
